// ===== rtl/mnva_pkg.sv =====
// ----------------------------------------------------------------------------
// mnva_pkg
// Shared types and constants for the MIDI note to CV voice allocator.
// ----------------------------------------------------------------------------
package mnva_pkg;

    // Default voice count
    localparam int VOICE_COUNT_DEF = 4;

    // Voices with a configurable channel register
    localparam int CHAN_REGS = 4;

    // Field widths
    localparam int CHAN_W  = 5;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int VOICE_W = 2;
    localparam int PITCH_W = 13;
    localparam int VCV_W   = 12;
    localparam int ENTRY_W = 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTES_ENABLED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_MODE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE0_CHANNEL = 3'd2;

    // Note operations
    localparam logic OP_NOTE_OFF = 1'b0;
    localparam logic OP_NOTE_ON  = 1'b1;

    // pitch = floor(note * 42.666), done as (note * ceil(42.666 * 2^20)) >> 20.
    // The rounding error stays below 5e-5 over all notes, and the fractional
    // part of note * 42.666 never exceeds 0.998, so the floor is exact.
    localparam int PITCH_MULT_W = 26;
    localparam logic [PITCH_MULT_W-1:0] PITCH_MULT = 26'd44738544;
    localparam int PITCH_SHIFT  = 20;
    localparam int PITCH_PROD_W = NOTE_W + PITCH_MULT_W;

    // velocity_cv = velocity * 32
    localparam int VCV_SHIFT = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } mnva_state_t;

endpackage

// ===== rtl/midi_note_voice_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// midi_note_voice_allocator_unit
// Assigns MIDI note-on/note-off events to CV voices and emits one result per
// voice driven, in ascending voice order.
// ----------------------------------------------------------------------------
// One event is accepted at a time. After acceptance a single entry compare
// unit walks the voice table one voice per cycle (the whole table, or less
// when a poly note-on finds a free voice), then a second walk over the voices
// hands out the results through the output register, at most one per cycle;
// voices without a hit are stepped over, and the sink can stall the walk. An
// event that hits nothing or arrives with notes disabled yields no
// transaction. Configuration writes are always taken.
module midi_note_voice_allocator_unit #(
    parameter int VOICE_COUNT = mnva_pkg::VOICE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mnva_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mnva_pkg::CHAN_W-1:0]      cfg_data,

    // Event input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [4:0] channel, [11:5] note, [18:12] velocity
    input  logic [0:0]  s_axis_tuser,   // [0] operation

    // Result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [1:0] voice, [2] write_cv, [15:3] pitch_cv,
                                        // [27:16] velocity_cv, [28] gate_on
    output logic        m_axis_tlast    // last
);

    localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(VOICE_COUNT - 1);

    localparam int CW = mnva_pkg::CHAN_W;
    localparam int NW = mnva_pkg::NOTE_W;
    localparam int VW = mnva_pkg::VEL_W;
    localparam int EW = mnva_pkg::ENTRY_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    mnva_pkg::mnva_state_t state_reg, state_next;

    logic                     notes_enabled_reg;
    logic                     poly_mode_reg;
    logic [CW-1:0]            voice_chan_reg [VOICE_COUNT];
    logic [EW-1:0]            map_tab_reg    [VOICE_COUNT];
    logic [EW-1:0]            poly_tab_reg   [VOICE_COUNT];

    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [VOICE_COUNT-1:0]   hit_reg, hit_next;
    logic [1:0]               count_reg, count_next;

    // event payload
    logic                     op_reg;
    logic [CW-1:0]            ch_reg;
    logic [NW-1:0]            note_reg;
    logic [mnva_pkg::PITCH_W-1:0] pitch_reg;
    logic [mnva_pkg::VCV_W-1:0]   vcv_reg;

    // output stage
    logic                     m_valid_reg, m_valid_next;
    logic [31:0]              m_data_reg, m_data_next;
    logic                     m_last_reg, m_last_next;

    // ------------------------------------------------------------------
    // Input unpacking and pitch/velocity scaling
    // ------------------------------------------------------------------
    logic                         in_op;
    logic [CW-1:0]                in_ch;
    logic [NW-1:0]                in_note;
    logic [VW-1:0]                in_vel;
    logic [mnva_pkg::PITCH_PROD_W-1:0] pitch_prod;
    logic                         in_fire;

    assign in_op   = s_axis_tuser[0];
    assign in_ch   = s_axis_tdata[4:0];
    assign in_note = s_axis_tdata[11:5];
    assign in_vel  = s_axis_tdata[18:12];
    assign pitch_prod = mnva_pkg::PITCH_PROD_W'(in_note)
                      * mnva_pkg::PITCH_PROD_W'(mnva_pkg::PITCH_MULT);

    assign s_axis_tready = (state_reg == mnva_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // ------------------------------------------------------------------
    // Shared entry compare unit (one voice per cycle)
    // ------------------------------------------------------------------
    logic [EW-1:0] cur_entry;
    logic          cur_busy;
    logic          chan_ok;
    logic          scan_hit;
    logic [EW-1:0] new_entry;
    logic          scan_stop;
    logic          idx_at_end;

    assign cur_entry  = poly_mode_reg ? poly_tab_reg[idx_reg] : map_tab_reg[idx_reg];
    assign cur_busy   = cur_entry[EW-1];
    assign chan_ok    = poly_mode_reg || (voice_chan_reg[idx_reg] == ch_reg);
    assign scan_hit   = chan_ok && ((op_reg == mnva_pkg::OP_NOTE_ON) ? !cur_busy
                        : (cur_busy && (cur_entry[NW-1:0] == note_reg)));
    assign new_entry  = (op_reg == mnva_pkg::OP_NOTE_ON) ? {1'b1, note_reg} : '0;
    assign idx_at_end = (idx_reg == IDX_LAST);
    // a poly note-on stops at the first free voice
    assign scan_stop  = idx_at_end
                      || (scan_hit && poly_mode_reg && (op_reg == mnva_pkg::OP_NOTE_ON));

    // ------------------------------------------------------------------
    // Result hand-out
    // ------------------------------------------------------------------
    logic                   out_free;
    logic                   cur_hit;
    logic                   emit_fire;
    logic                   hits_above;
    logic                   emit_last;
    logic                   emit_done;
    logic [IDX_W+1:0]       idx_ext;

    assign out_free   = !m_valid_reg || m_axis_tready;
    assign cur_hit    = hit_reg[idx_reg];
    assign emit_fire  = (state_reg == mnva_pkg::ST_EMIT) && cur_hit && out_free;
    assign hits_above = |((hit_reg >> idx_reg) >> 1);
    assign emit_last  = (count_reg == 2'd3) || !hits_above;
    assign emit_done  = (emit_fire && emit_last) || (!cur_hit && idx_at_end);
    assign idx_ext    = {2'b00, idx_reg};

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mnva_pkg::ST_IDLE:
            begin
                if (in_fire && notes_enabled_reg)
                begin
                    state_next = mnva_pkg::ST_SCAN;
                end
            end
            mnva_pkg::ST_SCAN:
            begin
                if (scan_stop)
                begin
                    if ((hit_reg != '0) || scan_hit)
                    begin
                        state_next = mnva_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = mnva_pkg::ST_IDLE;
                    end
                end
            end
            mnva_pkg::ST_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = mnva_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mnva_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer datapath and output stage
    // ------------------------------------------------------------------
    always_comb
    begin
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        count_next   = count_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;

        unique case (state_reg)
            mnva_pkg::ST_IDLE:
            begin
                idx_next   = '0;
                hit_next   = '0;
                count_next = '0;
            end
            mnva_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    hit_next[idx_reg] = 1'b1;
                end
                idx_next = scan_stop ? '0 : idx_reg + 1'b1;
            end
            mnva_pkg::ST_EMIT:
            begin
                if (emit_fire)
                begin
                    m_valid_next = 1'b1;
                    m_last_next  = emit_last;
                    m_data_next  = '0;
                    m_data_next[1:0] = idx_ext[1:0];
                    if (op_reg == mnva_pkg::OP_NOTE_ON)
                    begin
                        m_data_next[2]     = 1'b1;
                        m_data_next[15:3]  = pitch_reg;
                        m_data_next[27:16] = vcv_reg;
                        m_data_next[28]    = 1'b1;
                    end
                    count_next = count_reg + 1'b1;
                end
                if ((emit_fire || !cur_hit) && !idx_at_end)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mnva_pkg::ST_IDLE;
            idx_reg     <= '0;
            hit_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            hit_reg     <= hit_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            notes_enabled_reg <= 1'b1;
            poly_mode_reg     <= 1'b0;
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                voice_chan_reg[i] <= CW'(i + 1);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == mnva_pkg::CFG_NOTES_ENABLED)
            begin
                notes_enabled_reg <= cfg_data[0];
            end
            if (cfg_index == mnva_pkg::CFG_POLY_MODE)
            begin
                poly_mode_reg <= cfg_data[0];
            end
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                if ((i < mnva_pkg::CHAN_REGS)
                    && (cfg_index == mnva_pkg::CFG_VOICE0_CHANNEL
                                     + mnva_pkg::CFG_IDX_W'(i)))
                begin
                    voice_chan_reg[i] <= cfg_data;
                end
            end
        end
    end

    // voice tables, updated at the scanned entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                map_tab_reg[i]  <= '0;
                poly_tab_reg[i] <= '0;
            end
        end
        else if ((state_reg == mnva_pkg::ST_SCAN) && scan_hit)
        begin
            if (poly_mode_reg)
            begin
                poly_tab_reg[idx_reg] <= new_entry;
            end
            else
            begin
                map_tab_reg[idx_reg] <= new_entry;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= in_op;
            ch_reg    <= in_ch;
            note_reg  <= in_note;
            pitch_reg <= pitch_prod[mnva_pkg::PITCH_SHIFT +: mnva_pkg::PITCH_W];
            vcv_reg   <= mnva_pkg::VCV_W'(in_vel) << mnva_pkg::VCV_SHIFT;
        end
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

// ===== tb/sv/tb_midi_note_voice_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_note_voice_allocator_unit
// Self-checking bench for the MIDI voice allocator. A scoreboard keeps its
// own voice tables and register copies, predicts the CV writes of every
// accepted note event, and checks them in order against the result stream.
// Directed events cover the corner cases; random note-on/note-off runs over
// several register settings cover the rest, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_midi_note_voice_allocator_unit;
    import mnva_pkg::*;

    localparam int VOICES           = VOICE_COUNT_DEF;
    localparam int VIDX_W           = $clog2(VOICES);
    localparam int DRAIN_CYCLES     = 2 * VOICES + 4;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int RUN_LIMIT_NS     = 5_000_000;

    // register indexes past the voice channels decode to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO =
        CFG_IDX_W'(CFG_VOICE0_CHANNEL + CHAN_REGS);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic               write_cv;
        logic [PITCH_W-1:0] pitch_cv;
        logic [VCV_W-1:0]   velocity_cv;
        logic               gate_on;
        logic               last;
    } cv_write_t;

    class cv_scoreboard;
        bit                notes_enabled;
        bit                poly_mode;
        logic [CHAN_W-1:0] voice_chan [VOICES];
        logic [ENTRY_W-1:0] mapped_tab [VOICES];
        logic [ENTRY_W-1:0] poly_tab [VOICES];
        cv_write_t         expected_writes [$];
        int                errors;

        function new();
            notes_enabled = 1'b1;
            poly_mode     = 1'b0;
            errors        = 0;
            for (int i = 0; i < VOICES; i++)
            begin
                voice_chan[i] = CHAN_W'(i + 1);
                mapped_tab[i] = '0;
                poly_tab[i]   = '0;
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CHAN_W-1:0] val);
            if (idx == CFG_NOTES_ENABLED)
                notes_enabled = val[0];
            else if (idx == CFG_POLY_MODE)
                poly_mode = val[0];
            else if (idx >= CFG_VOICE0_CHANNEL && idx < CFG_SPARE_LO)
                voice_chan[VIDX_W'(idx - CFG_VOICE0_CHANNEL)] = val;
        endfunction

        // Note an accepted event: update the tables, queue the CV writes it causes.
        function void apply_event(logic op, logic [CHAN_W-1:0] ch, logic [NOTE_W-1:0] note,
                                  logic [VEL_W-1:0] vel);
            bit                 on;
            bit                 hit;
            bit                 have_prev;
            logic [ENTRY_W-1:0] slot;
            logic [PITCH_W-1:0] pitch;
            cv_write_t          prev;
            on        = (op == OP_NOTE_ON);
            have_prev = 1'b0;
            prev      = '0;
            pitch     = PITCH_W'((int'(note) * 42666) / 1000);
            if (!notes_enabled)
                return;
            for (int i = 0; i < VOICES; i++)
            begin
                hit = 1'b0;
                slot = poly_mode ? poly_tab[i] : mapped_tab[i];
                if (poly_mode || voice_chan[i] == ch)
                begin
                    if (on && !slot[ENTRY_W-1])
                    begin
                        slot = {1'b1, note};
                        hit  = 1'b1;
                    end
                    else if (!on && slot[ENTRY_W-1] && slot[NOTE_W-1:0] == note)
                    begin
                        slot = '0;
                        hit  = 1'b1;
                    end
                end
                if (poly_mode)
                    poly_tab[i] = slot;
                else
                    mapped_tab[i] = slot;
                if (hit)
                begin
                    if (have_prev)
                        expected_writes.push_back(prev);
                    prev.voice       = VOICE_W'(i);
                    prev.write_cv    = on;
                    prev.pitch_cv    = on ? pitch : '0;
                    prev.velocity_cv = on ? VCV_W'(vel) << VCV_SHIFT : '0;
                    prev.gate_on     = on;
                    prev.last        = 1'b0;
                    have_prev        = 1'b1;
                    if (poly_mode && on)
                        break;
                end
            end
            if (have_prev)
            begin
                prev.last = 1'b1;
                expected_writes.push_back(prev);
            end
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_cv_write(logic [31:0] data, logic tlast);
            cv_write_t want;
            if (expected_writes.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected CV write, expected none, actual data %h last %0d",
                         $time, data, tlast);
                return;
            end
            want = expected_writes.pop_front();
            compare("voice", want.voice, data[1:0]);
            compare("write_cv", want.write_cv, data[2]);
            compare("pitch_cv", want.pitch_cv, data[15:3]);
            compare("velocity_cv", want.velocity_cv, data[27:16]);
            compare("gate_on", want.gate_on, data[28]);
            compare("last", want.last, tlast);
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CHAN_W-1:0]    cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;   // [4:0] channel, [11:5] note, [18:12] velocity
    logic [0:0]           s_axis_tuser = '0;   // [0] operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;        // [1:0] voice, [2] write_cv, [15:3] pitch_cv,
                                               // [27:16] velocity_cv, [28] gate_on
    logic                 m_axis_tlast;

    cv_scoreboard sb = new();

    // stimulus-side view of the settings, used only to aim the random events
    logic [CHAN_W-1:0] chan_setting [VOICES];
    bit                poly_now;
    bit                steady;
    bit                sink_hold_req;
    logic [11:0]       held_q [$];             // {channel, note} of sounding notes

    midi_note_voice_allocator_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.apply_event(s_axis_tuser[0], s_axis_tdata[4:0], s_axis_tdata[11:5],
                               s_axis_tdata[18:12]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_cv_write(m_axis_tdata, m_axis_tlast);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHAN_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_voice_channels(input logic [CHAN_W-1:0] c0, input logic [CHAN_W-1:0] c1,
                                      input logic [CHAN_W-1:0] c2, input logic [CHAN_W-1:0] c3);
        chan_setting[0] = c0;
        chan_setting[1] = c1;
        chan_setting[2] = c2;
        chan_setting[3] = c3;
        for (int i = 0; i < VOICES; i++)
            write_reg(CFG_IDX_W'(CFG_VOICE0_CHANNEL + i), chan_setting[i]);
    endtask

    task automatic set_poly(input bit poly);
        poly_now = poly;
        write_reg(CFG_POLY_MODE, CHAN_W'(poly));
    endtask

    // valid stays up when the next gap is zero, so it is never dropped and raised in one step
    task automatic send_event(input logic op, input logic [CHAN_W-1:0] ch,
                              input logic [NOTE_W-1:0] note, input logic [VEL_W-1:0] vel);
        int gap;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'd0, vel, note, ch};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender pause: nothing offered until every expected write has come out
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic release_held();
        logic [11:0] pair;
        while (held_q.size() > 0)
        begin
            pair = held_q.pop_front();
            send_event(OP_NOTE_OFF, pair[11:7], pair[6:0], VEL_W'($urandom));
        end
    endtask

    // mostly well-formed on/off pairs, a little noise, all sounding notes released at the end
    task automatic play_phase(input int count);
        int                pick;
        int                idx;
        logic [CHAN_W-1:0] ch;
        logic [NOTE_W-1:0] note;
        logic [11:0]       pair;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            note = NOTE_W'($urandom);
            if (pick < 8)
            begin
                send_event(1'($urandom), CHAN_W'($urandom), note, VEL_W'($urandom));
            end
            else if (pick < 55 || held_q.size() == 0)
            begin
                if (!poly_now && $urandom_range(0, 9) < 8)
                    ch = chan_setting[$urandom_range(0, VOICES - 1)];
                else
                    ch = CHAN_W'($urandom_range(1, 16));
                held_q.push_back({ch, note});
                send_event(OP_NOTE_ON, ch, note, VEL_W'($urandom));
            end
            else
            begin
                idx  = $urandom_range(0, held_q.size() - 1);
                pair = held_q[idx];
                held_q.delete(idx);
                send_event(OP_NOTE_OFF, pair[11:7], pair[6:0], VEL_W'($urandom));
            end
        end
        release_held();
    endtask

    initial
    begin : sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (sink_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                sink_hold_req = 1'b0;
            end
            else
            begin
                stall = steady ? 0 : $urandom_range(0, 7);
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("** midi_note_voice_allocator_unit: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        for (int i = 0; i < VOICES; i++)
            chan_setting[i] = CHAN_W'(i + 1);
        poly_now      = 1'b0;
        steady        = 1'b0;
        sink_hold_req = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: mapped, voices on channels 1..4
        send_event(OP_NOTE_ON, 5'd1, 7'd0, 7'd0);        // note zero is held like any other
        send_event(OP_NOTE_OFF, 5'd1, 7'd0, 7'd127);
        send_event(OP_NOTE_OFF, 5'd1, 7'd0, 7'd0);       // free voice never matches
        send_event(OP_NOTE_ON, 5'd4, 7'd127, 7'd127);    // top of both CV ranges
        send_event(OP_NOTE_ON, 5'd4, 7'd60, 7'd64);      // voice busy: dropped
        send_event(OP_NOTE_OFF, 5'd4, 7'd60, 7'd0);      // wrong note: no match
        send_event(OP_NOTE_OFF, 5'd4, 7'd127, 7'd0);
        send_event(OP_NOTE_ON, 5'd17, 7'd5, 7'd1);       // channels outside 1..16
        send_event(OP_NOTE_ON, 5'd0, 7'd5, 7'd1);
        wait_idle();

        // every voice on one channel; spare indexes must change nothing
        set_voice_channels(5'd5, 5'd5, 5'd5, 5'd5);
        write_reg(CFG_SPARE_LO, 5'd31);
        write_reg(CFG_SPARE_HI, 5'd31);
        send_event(OP_NOTE_ON, 5'd5, 7'd64, 7'd100);     // fills all four voices
        send_event(OP_NOTE_OFF, 5'd5, 7'd64, 7'd0);
        wait_idle();

        set_poly(1'b1);
        send_event(OP_NOTE_ON, 5'd9, 7'd10, 7'd11);
        send_event(OP_NOTE_ON, 5'd2, 7'd20, 7'd22);
        send_event(OP_NOTE_ON, 5'd16, 7'd20, 7'd33);
        send_event(OP_NOTE_ON, 5'd9, 7'd30, 7'd44);
        send_event(OP_NOTE_ON, 5'd9, 7'd50, 7'd55);      // no free voice: dropped
        send_event(OP_NOTE_OFF, 5'd3, 7'd20, 7'd0);      // frees both holders of the note
        send_event(OP_NOTE_ON, 5'd7, 7'd40, 7'd66);
        wait_idle();

        write_reg(CFG_NOTES_ENABLED, 5'd0);
        send_event(OP_NOTE_ON, 5'd9, 7'd70, 7'd77);
        send_event(OP_NOTE_OFF, 5'd9, 7'd10, 7'd0);
        wait_idle();

        // mode switches keep both tables
        write_reg(CFG_NOTES_ENABLED, 5'd1);
        set_poly(1'b0);
        send_event(OP_NOTE_ON, 5'd5, 7'd1, 7'd88);
        send_event(OP_NOTE_OFF, 5'd5, 7'd1, 7'd0);
        wait_idle();
        set_poly(1'b1);
        send_event(OP_NOTE_OFF, 5'd1, 7'd30, 7'd0);
        send_event(OP_NOTE_OFF, 5'd1, 7'd10, 7'd0);
        send_event(OP_NOTE_OFF, 5'd1, 7'd40, 7'd0);
        wait_idle();

        set_poly(1'b0);
        set_voice_channels(5'd1, 5'd2, 5'd3, 5'd4);
        play_phase(20);
        wait_idle();

        set_voice_channels(5'd16, 5'd16, 5'd9, 5'd9);
        play_phase(20);
        wait_idle();

        // long sink stall while events keep coming
        set_poly(1'b1);
        sink_hold_req = 1'b1;
        play_phase(20);
        wait_idle();

        steady = 1'b1;
        play_phase(20);
        wait_idle();
        steady = 1'b0;

        set_poly(1'b0);
        set_voice_channels(5'd0, 5'd31, 5'd7, 5'd16);
        play_phase(14);
        wait_idle();

        write_reg(CFG_NOTES_ENABLED, 5'd0);
        play_phase(6);
        wait_idle();
        write_reg(CFG_NOTES_ENABLED, 5'd1);
        play_phase(6);
        wait_idle();

        if (sb.errors == 0)
            $display("** midi_note_voice_allocator_unit: PASSED **");
        else
            $display("** midi_note_voice_allocator_unit: FAILED **");
        $finish;
    end

endmodule
